FILE: design/dbat_pkg.sv
package dbat_pkg;

   localparam int SLOTS = 8;
   localparam int SLOT_W = $clog2(SLOTS);

   typedef enum logic [1:0] {
      FUNC_BYTE  = 2'd0,
      FUNC_OPEN  = 2'd1,
      FUNC_CLOSE = 2'd2,
      FUNC_NONE  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      KIND_DESC  = 2'd0,
      KIND_SECT  = 2'd1,
      KIND_OPEN  = 2'd2,
      KIND_CLOSE = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ST_ACCEPTED  = 3'd0,
      ST_COMPLETE  = 3'd1,
      ST_DUPLICATE = 3'd2,
      ST_UNKNOWN   = 3'd3,
      ST_OTHER     = 3'd4,
      ST_BADNUM    = 3'd5,
      ST_OPEN      = 3'd6,
      ST_FULL      = 3'd7
   } status_type;

   typedef enum logic [3:0] {
      PH_HDR    = 4'd0,
      PH_BQLEN  = 4'd1,
      PH_BQSKIP = 4'd2,
      PH_TSLEN  = 4'd3,
      PH_ENTRY  = 4'd4,
      PH_TAG    = 4'd5,
      PH_LEN    = 4'd6,
      PH_PAY    = 4'd7,
      PH_DONE   = 4'd8
   } phase_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [7:0]  section_byte;
      logic        section_end;
      logic [15:0] bouquet;
   } req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] stream_id;
      logic [7:0]  descriptor_tag;
      logic [7:0]  payload_byte;
      logic [8:0]  byte_offset;
      logic        descriptor_last;
      logic [2:0]  status;
      logic [2:0]  slot;
      logic        last_result;
   } rsp_type;

   typedef struct packed {
      logic        hit;
      logic [SLOT_W-1:0] idx;
   } match_type;

endpackage

FILE: design/dbat_if.sv
interface dbat_req_if;
   import dbat_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dbat_rsp_if;
   import dbat_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

FILE: design/dvb_bat_section_parser.sv
// DVB BAT section parser. Takes one request transfer per cycle (section byte,
// open bouquet, close all) and gives at most one response per request through
// a registered output stage. A new request is taken whenever the output stage
// is empty or being drained, so throughput is one byte per clock; the section
// header is resolved in the cycle of byte 7 against eight bouquet slots, each
// holding a 256-bit received-section map.
module dvb_bat_section_parser (
   input  logic        clock,
   input  logic        reset,
   dbat_req_if.sink    req,
   dbat_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);
   import dbat_pkg::*;

   logic [7:0]  tid_ff;
   logic        step, emit, sect_now, tid_ok;
   logic [15:0] hdr_bq;
   logic [7:0]  sec, last;
   status_type  sect_status, open_status;
   logic [2:0]  sect_slot, open_slot;
   rsp_type     out_in, out_ff;
   logic        vld_ff;

   assign req.ready = !vld_ff || rsp.ready;
   assign step = req.valid && req.ready;
   assign rsp.valid = vld_ff;
   assign rsp.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) tid_ff <= 8'd74;
      else if (csr_we) tid_ff <= csr_wdata;
   end

   dbat_slots u_slots (
      .clock, .reset, .step, .req(req.data), .hdr_bq, .sect_now, .tid_ok,
      .sec, .last, .sect_status, .sect_slot, .open_status, .open_slot
   );

   dbat_parser u_parser (
      .clock, .reset, .step, .req(req.data), .table_id(tid_ff), .sect_status,
      .sect_slot, .open_status, .open_slot, .hdr_bq, .sect_now, .tid_ok, .sec,
      .last, .emit, .rsp(out_in)
   );

   always_ff @(posedge clock) begin
      if (reset) vld_ff <= 1'b0;
      else if (step) vld_ff <= emit;
      else if (rsp.ready) vld_ff <= 1'b0;
      if (step && emit) out_ff <= out_in;
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.data))
      else $error("response dropped while stalled");
   a_noaccept: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |-> !req.ready)
      else $error("request taken over a stalled response");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> rsp.data.last_result)
      else $error("last_result low");
endmodule

FILE: design/dbat_slots.sv
module dbat_slots (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  dbat_pkg::req_type          req,
   input  logic [15:0]                hdr_bq,
   input  logic                       sect_now,
   input  logic                       tid_ok,
   input  logic [7:0]                 sec,
   input  logic [7:0]                 last,
   output dbat_pkg::status_type       sect_status,
   output logic [2:0]                 sect_slot,
   output dbat_pkg::status_type       open_status,
   output logic [2:0]                 open_slot
);
   import dbat_pkg::*;

   logic [15:0]      bq_ff [SLOTS];
   logic [SLOTS-1:0] valid_ff;
   logic [255:0]     map_ff [SLOTS];
   match_type        sm, om, fr;
   logic [255:0]     cur_map, new_map, need;

   always_comb begin
      sm = '0;
      om = '0;
      fr = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (valid_ff[s] && bq_ff[s] == hdr_bq) sm = '{1'b1, SLOT_W'(s)};
         if (valid_ff[s] && bq_ff[s] == req.bouquet) om = '{1'b1, SLOT_W'(s)};
         if (!valid_ff[s]) fr = '{1'b1, SLOT_W'(s)};
      end
      cur_map = map_ff[sm.idx];
      new_map = cur_map | (256'd1 << sec);
      for (int i = 0; i < 256; i++) need[i] = (8'(i) <= last);
      sect_slot = 3'(sm.idx);
      if (!sm.hit) begin
         sect_status = ST_UNKNOWN;
         sect_slot = 3'd0;
      end else if (!tid_ok) sect_status = ST_OTHER;
      else if (sec > last) sect_status = ST_BADNUM;
      else if (cur_map[sec]) sect_status = ST_DUPLICATE;
      else if ((new_map & need) == need) sect_status = ST_COMPLETE;
      else sect_status = ST_ACCEPTED;
      if (om.hit) begin
         open_status = ST_OPEN;
         open_slot = 3'(om.idx);
      end else if (fr.hit) begin
         open_status = ST_ACCEPTED;
         open_slot = 3'(fr.idx);
      end else begin
         open_status = ST_FULL;
         open_slot = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.func == FUNC_CLOSE)) begin
         valid_ff <= '0;
         for (int s = 0; s < SLOTS; s++) begin
            map_ff[s] <= '0;
            bq_ff[s] <= '0;
         end
      end else if (step) begin
         if (sect_now && sm.hit) begin
            if (sect_status == ST_COMPLETE) map_ff[sm.idx] <= '0;
            else if (sect_status == ST_ACCEPTED) map_ff[sm.idx] <= new_map;
         end
         if (req.func == FUNC_OPEN && !om.hit && fr.hit) begin
            valid_ff[fr.idx] <= 1'b1;
            bq_ff[fr.idx] <= req.bouquet;
            map_ff[fr.idx] <= '0;
         end
      end
   end
endmodule

FILE: design/dbat_parser.sv
module dbat_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  dbat_pkg::req_type    req,
   input  logic [7:0]           table_id,
   input  dbat_pkg::status_type sect_status,
   input  logic [2:0]           sect_slot,
   input  dbat_pkg::status_type open_status,
   input  logic [2:0]           open_slot,
   output logic [15:0]          hdr_bq,
   output logic                 sect_now,
   output logic                 tid_ok,
   output logic [7:0]           sec,
   output logic [7:0]           last,
   output logic                 emit,
   output dbat_pkg::rsp_type    rsp
);
   import dbat_pkg::*;

   phase_type   ph_ff, ph_in;
   logic [3:0]  pos_ff, pos_in;
   logic [7:0]  hb_ff [8];
   logic [7:0]  hold_ff, hold_in, tag_ff, tag_in;
   logic [2:0]  slot_ff, slot_in;
   logic [11:0] bq_ff, bq_in, loop_ff, loop_in, ent_ff, ent_in;
   logic [11:0] loop_d, ent_d;
   logic [7:0]  dl_ff, dl_in;
   logic [8:0]  off_ff, off_in;
   logic [15:0] sid_ff, sid_in;
   logic [7:0]  b;

   assign b = req.section_byte;
   assign sect_now = req.func == FUNC_BYTE && ph_ff == PH_HDR && pos_ff == 4'd7;
   assign hdr_bq = {hb_ff[3], hb_ff[4]};
   assign sec = hb_ff[6];
   assign last = b;
   assign tid_ok = hb_ff[0] == table_id;
   assign loop_d = loop_ff - 12'd1;
   assign ent_d = ent_ff - 12'd1;

   always_comb begin
      ph_in = ph_ff; pos_in = pos_ff; hold_in = hold_ff; tag_in = tag_ff;
      slot_in = slot_ff; bq_in = bq_ff; loop_in = loop_ff; ent_in = ent_ff;
      dl_in = dl_ff; off_in = off_ff; sid_in = sid_ff;
      emit = 1'b0;
      rsp = '0;
      rsp.last_result = 1'b1;
      unique case (req.func)
         FUNC_OPEN: begin
            emit = 1'b1;
            rsp.kind = KIND_OPEN;
            rsp.status = open_status;
            rsp.slot = open_slot;
         end
         FUNC_CLOSE: begin
            emit = 1'b1;
            rsp.kind = KIND_CLOSE;
         end
         FUNC_NONE: ;
         FUNC_BYTE: begin
            unique case (ph_ff)
               PH_HDR: begin
                  if (pos_ff == 4'd7) begin
                     emit = 1'b1;
                     rsp.kind = KIND_SECT;
                     rsp.status = sect_status;
                     rsp.slot = sect_slot;
                     slot_in = sect_slot;
                     ph_in = (sect_status == ST_ACCEPTED || sect_status == ST_COMPLETE)
                        ? PH_BQLEN : PH_DONE;
                  end
                  pos_in = pos_ff + 4'd1;
               end
               PH_BQLEN: begin
                  if (pos_ff == 4'd8) begin
                     hold_in = b;
                     pos_in = 4'd9;
                  end else begin
                     bq_in = {hold_ff[3:0], b};
                     ph_in = (bq_in != 12'd0) ? PH_BQSKIP : PH_TSLEN;
                     pos_in = 4'd0;
                  end
               end
               PH_BQSKIP: begin
                  bq_in = bq_ff - 12'd1;
                  if (bq_in == 12'd0) ph_in = PH_TSLEN;
               end
               PH_TSLEN: begin
                  if (pos_ff == 4'd0) begin
                     hold_in = b;
                     pos_in = 4'd1;
                  end else begin
                     loop_in = {hold_ff[3:0], b};
                     ph_in = (loop_in != 12'd0) ? PH_ENTRY : PH_DONE;
                     pos_in = 4'd0;
                  end
               end
               PH_ENTRY: begin
                  if (pos_ff == 4'd0) sid_in = {b, 8'd0};
                  else if (pos_ff == 4'd1) sid_in = {sid_ff[15:8], b};
                  else if (pos_ff == 4'd4) hold_in = b;
                  loop_in = loop_d;
                  if (pos_ff == 4'd5) begin
                     ent_in = {hold_ff[3:0], b};
                     pos_in = 4'd0;
                     if (ent_in != 12'd0) ph_in = PH_TAG;
                  end else pos_in = pos_ff + 4'd1;
                  if (loop_d == 12'd0) ph_in = PH_DONE;
               end
               PH_TAG, PH_LEN, PH_PAY: begin
                  loop_in = loop_d;
                  ent_in = ent_d;
                  emit = 1'b1;
                  rsp.descriptor_last = loop_d == 12'd0 || ent_d == 12'd0;
                  if (ph_ff == PH_TAG) begin
                     tag_in = b;
                     off_in = 9'd0;
                     ph_in = PH_LEN;
                  end else if (ph_ff == PH_LEN) begin
                     off_in = 9'd1;
                     dl_in = b;
                     if (b == 8'd0) begin
                        rsp.descriptor_last = 1'b1;
                        ph_in = PH_TAG;
                     end else ph_in = PH_PAY;
                  end else begin
                     off_in = off_ff + 9'd1;
                     dl_in = dl_ff - 8'd1;
                     if (dl_in == 8'd0) begin
                        rsp.descriptor_last = 1'b1;
                        ph_in = PH_TAG;
                     end
                  end
                  rsp.kind = KIND_DESC;
                  rsp.stream_id = sid_in;
                  rsp.descriptor_tag = tag_in;
                  rsp.payload_byte = b;
                  rsp.byte_offset = off_in;
                  rsp.slot = slot_ff;
                  if (loop_d == 12'd0) ph_in = PH_DONE;
                  else if (ent_d == 12'd0) begin
                     ph_in = PH_ENTRY;
                     pos_in = 4'd0;
                  end
               end
               default: ;
            endcase
            if (req.section_end) begin
               ph_in = PH_HDR;
               pos_in = 4'd0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_HDR; pos_ff <= '0; hold_ff <= '0; tag_ff <= '0;
         slot_ff <= '0; bq_ff <= '0; loop_ff <= '0; ent_ff <= '0;
         dl_ff <= '0; off_ff <= '0; sid_ff <= '0;
         for (int i = 0; i < 8; i++) hb_ff[i] <= '0;
      end else if (step) begin
         ph_ff <= ph_in; pos_ff <= pos_in; hold_ff <= hold_in; tag_ff <= tag_in;
         slot_ff <= slot_in; bq_ff <= bq_in; loop_ff <= loop_in; ent_ff <= ent_in;
         dl_ff <= dl_in; off_ff <= off_in; sid_ff <= sid_in;
         if (req.func == FUNC_BYTE && ph_ff == PH_HDR) hb_ff[pos_ff[2:0]] <= b;
      end
   end
endmodule
